/* hdl/radio_credit_chunk_sender_defines.svh */
`ifndef RADIO_CREDIT_CHUNK_SENDER_DEFINES_SVH
`define RADIO_CREDIT_CHUNK_SENDER_DEFINES_SVH

// Assertion helpers. Each one expects the enclosing module to have clk and
// an active-low rst_n in scope.

// The consequent must hold in the same cycle as the antecedent.
`define RCCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rccs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rccs_pkg;

    // Request kinds carried in req_type.
    localparam logic [1:0] REQ_REPORT  = 2'd0;
    localparam logic [1:0] REQ_TIMEOUT = 2'd1;
    localparam logic [1:0] REQ_CHUNK   = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_MAX  = 2'd2;

    localparam int unsigned CFG_DATA_W = 16;

    // Register values after reset.
    localparam logic [15:0] TIMEOUT_MS_RESET = 16'd500;
    localparam logic [7:0]  SLOT_COUNT_RESET = 8'd4;
    localparam logic [7:0]  CHUNK_MAX_RESET  = 8'd30;

    localparam logic [7:0]  COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_ms;
        logic        report_present;
        logic [7:0]  free_reported;
        logic [11:0] buf_avail;
        logic [11:0] frame_len;
        logic        link_accept;
    } item_t;

    typedef struct packed {
        logic [7:0] chunk_len;
        logic       stop;
        logic [7:0] slots_free;
        logic [7:0] outstanding_now;
    } result_t;

    typedef struct packed {
        logic [15:0] timeout_ms;
        logic [7:0]  slot_count;
        logic [7:0]  chunk_max;
    } cfg_t;

endpackage

`default_nettype wire

/* hdl/rccs_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Input item channel.
interface rccs_req_if;
    import rccs_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Result channel.
interface rccs_rsp_if;
    import rccs_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface rccs_cfg_if;
    import rccs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

/* hdl/radio_credit_chunk_sender.sv */
// A result beat passes the input register and then the result register, and
// can wait in either while the result side is stalled.
// Throughput: one item per cycle; the input stage frees up whenever the result
// register is empty or its beat is being taken, so items can follow back to back.
// Reset (rst_n low, asynchronous): both stages empty, credit state cleared, and
// the registers return to timeout_ms 500, slot_count 4, chunk_max 30.
`timescale 1ns / 1ps
`default_nettype none
`include "radio_credit_chunk_sender_defines.svh"

module radio_credit_chunk_sender #(
    parameter int unsigned BUF_BYTES = 2048
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rccs_req_if.sink    req,
    rccs_rsp_if.source  rsp,
    rccs_cfg_if.sink    cfg
);
    import rccs_pkg::*;

    // Stage one holds the accepted item. Its state effects are applied by the
    // credit core at the same edge at which it moves into the result register,
    // so the next item always sees fully updated credit and frame state.
    logic    s1_valid_reg;
    item_t   s1_item_reg;

    // Result register. It acts as the skid stage between the two sides: a new
    // input beat can be taken while a finished result still waits here.
    logic    out_valid_reg;
    result_t out_data_reg;

    cfg_t    cfg_regs;
    result_t core_result;

    logic    out_free;
    logic    s1_adv;
    logic    in_fire;

    rccs_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    rccs_credit_core #(
        .BUF_BYTES (BUF_BYTES)
    ) u_credit_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_regs),
        .fire   (s1_adv),
        .item   (s1_item_reg),
        .result (core_result)
    );

    // The result register can load when it is empty or its beat leaves now.
    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_adv    = s1_valid_reg && out_free;
    // Stage one can take a beat when it is empty or is moving on this cycle.
    assign req.ready = !s1_valid_reg || out_free;
    assign in_fire   = req.valid && req.ready;

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; the valid flags above qualify them.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= req.data;
        end
        if (s1_adv)
        begin
            out_data_reg <= core_result;
        end
    end

    // Back pressure reaches the input only when both stages are full and stalled.
    `RCCS_ASSERT_SAME(a_stall_only_when_full, !req.ready, s1_valid_reg && out_valid_reg && !rsp.ready, "input stalled while a stage had room")
    // A result beat appears only after an item has sat in stage one.
    `RCCS_ASSERT_SAME(a_result_from_stage, $rose(out_valid_reg), $past(s1_valid_reg), "result appeared without a staged item")
    // An item that leaves stage one is offered as a result in the next cycle.
    `RCCS_ASSERT_NEXT(a_stage_to_result, s1_adv, out_valid_reg, "advanced item did not reach the result register")

endmodule

`default_nettype wire

/* hdl/rccs_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module rccs_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    rccs_cfg_if.sink           cfg,
    output rccs_pkg::cfg_t     regs
);
    import rccs_pkg::*;

    cfg_t regs_reg;

    // Writes are always taken; an unknown index is dropped.
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.timeout_ms <= TIMEOUT_MS_RESET;
            regs_reg.slot_count <= SLOT_COUNT_RESET;
            regs_reg.chunk_max  <= CHUNK_MAX_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_TIMEOUT_MS: regs_reg.timeout_ms <= cfg.wdata;
                CFG_SLOT_COUNT: regs_reg.slot_count <= cfg.wdata[7:0];
                CFG_CHUNK_MAX:  regs_reg.chunk_max  <= cfg.wdata[7:0];
                default:        ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/rccs_credit_core.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "radio_credit_chunk_sender_defines.svh"

module rccs_credit_core #(
    parameter int unsigned BUF_BYTES = 2048
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rccs_pkg::cfg_t cfg,
    input  wire logic           fire,
    input  wire rccs_pkg::item_t item,
    output rccs_pkg::result_t   result
);
    import rccs_pkg::*;

    localparam logic [12:0] BUF_LIMIT = 13'(BUF_BYTES);

    logic [7:0]  outstanding_reg,      outstanding_next;
    logic [7:0]  last_free_reg,        last_free_next;
    logic [31:0] last_report_time_reg, last_report_time_next;
    logic        report_seen_reg,      report_seen_next;
    logic [11:0] frame_left_reg,       frame_left_next;

    logic [11:0] avail_sat;
    logic [11:0] flen_sat;
    logic [7:0]  free_now;
    logic [7:0]  rep_clamp;
    logic [7:0]  rise;
    logic [31:0] elapsed;
    logic        timed_out;
    logic [11:0] frame_base;
    logic [11:0] chunk_cap;
    logic [11:0] send_len;
    logic [7:0]  sent;
    logic        stop;

    always_comb
    begin
        // Buffer figures beyond the buffer size are taken as the size.
        avail_sat = ({1'b0, item.buf_avail} > BUF_LIMIT) ? BUF_LIMIT[11:0] : item.buf_avail;
        flen_sat  = ({1'b0, item.frame_len} > BUF_LIMIT) ? BUF_LIMIT[11:0] : item.frame_len;

        free_now  = (outstanding_reg >= cfg.slot_count) ? 8'd0
                                                        : cfg.slot_count - outstanding_reg;
        rep_clamp = (item.free_reported < cfg.slot_count) ? item.free_reported
                                                          : cfg.slot_count;
        rise      = rep_clamp - last_free_reg;
        elapsed   = item.now_ms - last_report_time_reg;
        timed_out = elapsed > {16'd0, cfg.timeout_ms};

        // A new frame length is picked up only when none is in progress.
        frame_base = (frame_left_reg == 12'd0) ? flen_sat : frame_left_reg;
        chunk_cap  = (frame_base < {4'd0, cfg.chunk_max}) ? frame_base
                                                          : {4'd0, cfg.chunk_max};
        send_len   = (chunk_cap < avail_sat) ? chunk_cap : avail_sat;

        outstanding_next      = outstanding_reg;
        last_free_next        = last_free_reg;
        last_report_time_next = last_report_time_reg;
        report_seen_next      = report_seen_reg;
        frame_left_next       = frame_left_reg;
        sent                  = 8'd0;
        stop                  = 1'b0;

        case (item.req_type)
            REQ_REPORT:
            begin
                if (item.report_present)
                begin
                    if (rep_clamp > last_free_reg)
                    begin
                        outstanding_next = (outstanding_reg > rise) ? outstanding_reg - rise
                                                                    : 8'd0;
                    end
                    last_free_next        = rep_clamp;
                    last_report_time_next = item.now_ms;
                    report_seen_next      = 1'b1;
                end
            end
            REQ_TIMEOUT:
            begin
                if ((outstanding_reg != 8'd0) && report_seen_reg && timed_out)
                begin
                    outstanding_next      = outstanding_reg - 8'd1;
                    last_report_time_next = item.now_ms;
                end
            end
            REQ_CHUNK:
            begin
                stop = 1'b1;
                if ((free_now != 8'd0) && (avail_sat != 12'd0))
                begin
                    frame_left_next = frame_base;
                    if ((frame_base != 12'd0) && (send_len != 12'd0) && item.link_accept)
                    begin
                        sent             = send_len[7:0];
                        frame_left_next  = frame_base - send_len;
                        outstanding_next = (outstanding_reg != COUNT_MAX)
                                           ? outstanding_reg + 8'd1 : outstanding_reg;
                        stop             = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        result.chunk_len       = sent;
        result.stop            = stop;
        result.slots_free      = (outstanding_next >= cfg.slot_count)
                                 ? 8'd0 : cfg.slot_count - outstanding_next;
        result.outstanding_now = outstanding_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg      <= 8'd0;
            last_free_reg        <= 8'd0;
            last_report_time_reg <= 32'd0;
            report_seen_reg      <= 1'b0;
            frame_left_reg       <= 12'd0;
        end
        else if (fire)
        begin
            outstanding_reg      <= outstanding_next;
            last_free_reg        <= last_free_next;
            last_report_time_reg <= last_report_time_next;
            report_seen_reg      <= report_seen_next;
            frame_left_reg       <= frame_left_next;
        end
    end

    `RCCS_ASSERT_SAME(a_sent_not_stopped, fire && (result.chunk_len != 8'd0), !result.stop && (result.chunk_len <= cfg.chunk_max), "sent chunk is flagged stop or exceeds chunk_max")
    `RCCS_ASSERT_NEXT(a_only_chunk_raises, fire && (item.req_type != REQ_CHUNK), outstanding_reg <= $past(outstanding_reg), "outstanding rose on a non-chunk item")
    `RCCS_ASSERT_SAME(a_free_within_slots, fire, result.slots_free <= cfg.slot_count, "slots_free exceeds slot_count")

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps

// Regression bench for the radio credit chunk sender.
//
// The bench keeps its own copy of the credit ledger (outstanding chunks, the
// last free-slot report, the time of that report and the frame still to send)
// and of the three configuration registers. Every item beat that the block
// takes is run through that ledger at once, and the status it should produce
// is queued. A separate process takes status beats from the block, pops the
// oldest queued status and compares it field by field.
//
// Both handshakes are sampled on the falling clock edge, after the bench and
// the block have changed anything, so a beat seen there is the beat that the
// next rising edge takes. All inputs change only by nonblocking assignment on
// a rising edge.
module tb;
    import rccs_pkg::*;

    localparam int unsigned BUF_BYTES     = 2048;
    // Upper bound on the whole run.
    localparam int unsigned CYCLE_LIMIT   = 200000;
    // Each item beat passes the block's input register and then its result register;
    // the extra wait after the last status beat lets a stray beat be caught.
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned IDLE_PCT      = 13;
    localparam int unsigned PHASE_ITEMS   = 225;
    localparam int unsigned STREAM_ITEMS  = 200;

    // The package names only the three meaningful request kinds. The fourth
    // encoding must be ignored by the block.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    rccs_req_if req_ch ();
    rccs_rsp_if rsp_ch ();
    rccs_cfg_if cfg_ch ();

    radio_credit_chunk_sender #(
        .BUF_BYTES (BUF_BYTES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Register values as the bench believes them to be.
    logic [15:0] cfg_timeout;
    logic [7:0]  cfg_slots;
    logic [7:0]  cfg_chunk;

    // Credit ledger, mirrored from the block's behavior.
    logic [7:0]  owed_chunks;
    logic [7:0]  prev_free;
    logic [31:0] prev_report_ms;
    logic        report_heard;
    logic [11:0] frame_remaining;

    // Status beats predicted and not yet delivered, oldest first.
    result_t awaited_status[$];

    int unsigned fault_count;
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;

    // Running millisecond clock that random items are stamped with.
    logic [31:0] sim_ms;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Slots still free for the radio, floored at zero when the slot count
    // has been lowered below the number of chunks in flight.
    function automatic logic [7:0] slots_open();
        return (owed_chunks >= cfg_slots) ? 8'd0 : cfg_slots - owed_chunks;
    endfunction

    // Applies one item to the ledger and returns the status it must produce.
    function automatic result_t advance_credit(input item_t it);
        result_t     status;
        logic [11:0] avail;
        logic [11:0] flen;
        logic [7:0]  seen_free;
        logic [7:0]  rise;
        logic [11:0] n;
        logic [31:0] quiet_ms;
        status = '0;
        // Buffer figures above the buffer size are taken as the buffer size.
        avail = (it.buf_avail > 12'(BUF_BYTES)) ? 12'(BUF_BYTES) : it.buf_avail;
        flen  = (it.frame_len > 12'(BUF_BYTES)) ? 12'(BUF_BYTES) : it.frame_len;
        case (it.req_type)
            REQ_REPORT:
            begin
                // A report without its byte changes nothing at all.
                if (it.report_present)
                begin
                    seen_free = (it.free_reported < cfg_slots) ? it.free_reported : cfg_slots;
                    // Only a rise over the last report hands credit back.
                    if (seen_free > prev_free)
                    begin
                        rise = seen_free - prev_free;
                        owed_chunks = (rise >= owed_chunks) ? 8'd0 : owed_chunks - rise;
                    end
                    prev_free      = seen_free;
                    prev_report_ms = it.now_ms;
                    report_heard   = 1'b1;
                end
            end
            REQ_TIMEOUT:
            begin
                // The elapsed time wraps with the 32-bit millisecond clock.
                quiet_ms = it.now_ms - prev_report_ms;
                if (owed_chunks != 8'd0 && report_heard && quiet_ms > {16'd0, cfg_timeout})
                begin
                    owed_chunks    = owed_chunks - 8'd1;
                    prev_report_ms = it.now_ms;
                end
            end
            REQ_CHUNK:
            begin
                status.stop = 1'b1;
                if (slots_open() != 8'd0 && avail != 12'd0)
                begin
                    // A frame latched here stays latched even if the link refuses.
                    if (frame_remaining == 12'd0)
                    begin
                        frame_remaining = flen;
                    end
                    if (frame_remaining != 12'd0)
                    begin
                        n = frame_remaining;
                        if ({4'd0, cfg_chunk} < n)
                        begin
                            n = {4'd0, cfg_chunk};
                        end
                        if (avail < n)
                        begin
                            n = avail;
                        end
                        if (n != 12'd0 && it.link_accept)
                        begin
                            status.chunk_len = n[7:0];
                            status.stop      = 1'b0;
                            frame_remaining  = frame_remaining - n;
                            if (owed_chunks != COUNT_MAX)
                            begin
                                owed_chunks = owed_chunks + 8'd1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                // The unused request kind is ignored.
            end
        endcase
        status.slots_free      = slots_open();
        status.outstanding_now = owed_chunks;
        return status;
    endfunction

    function automatic item_t make_item(input logic [1:0] kind, input logic [31:0] stamp,
                                        input logic present, input logic [7:0] reported,
                                        input logic [11:0] avail, input logic [11:0] flen,
                                        input logic accept);
        item_t it;
        it.req_type       = kind;
        it.now_ms         = stamp;
        it.report_present = present;
        it.free_reported  = reported;
        it.buf_avail      = avail;
        it.frame_len      = flen;
        it.link_accept    = accept;
        return it;
    endfunction

    // Random item biased toward traffic that moves the ledger: chunk attempts
    // on real frames, reports that return credit, and timeout checks aimed at
    // the timeout boundary. A small share is pure noise.
    function automatic item_t random_item();
        item_t       it;
        int unsigned pick;
        int unsigned shape;
        int unsigned top_free;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 3)
        begin
            sim_ms = $urandom;
        end
        else
        begin
            sim_ms = sim_ms + $urandom_range(300);
        end
        top_free = (cfg_slots == 8'hFF) ? 255 : cfg_slots + 1;

        it.req_type       = REQ_CHUNK;
        it.now_ms         = sim_ms;
        it.report_present = ($urandom_range(99) < 90);
        it.free_reported  = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                     : 8'($urandom_range(top_free));
        shape = $urandom_range(19);
        if (shape == 0)
        begin
            it.buf_avail = 12'd0;
        end
        else if (shape == 1)
        begin
            it.buf_avail = 12'($urandom_range(4095));
        end
        else if (shape == 2)
        begin
            it.buf_avail = 12'($urandom_range(2056, 2040));
        end
        else
        begin
            it.buf_avail = 12'($urandom_range(300, 1));
        end
        shape = $urandom_range(19);
        if (shape < 2)
        begin
            it.frame_len = 12'd0;
        end
        else if (shape == 2)
        begin
            it.frame_len = 12'($urandom_range(4095));
        end
        else
        begin
            it.frame_len = 12'($urandom_range(400, 1));
        end
        it.link_accept = ($urandom_range(99) < 85);

        if (pick < 45)
        begin
            it.req_type = REQ_CHUNK;
        end
        else if (pick < 75)
        begin
            it.req_type = REQ_REPORT;
        end
        else if (pick < 92)
        begin
            it.req_type = REQ_TIMEOUT;
            // Once a report has been heard, half the checks land within two milliseconds of the boundary.
            if (report_heard && $urandom_range(1) == 1)
            begin
                it.now_ms = prev_report_ms + {16'd0, cfg_timeout} + $urandom_range(4) - 32'd2;
                sim_ms    = it.now_ms;
            end
        end
        else if (pick < 96)
        begin
            it.req_type = REQ_UNUSED;
        end
        else
        begin
            it.req_type       = 2'($urandom_range(3));
            it.now_ms         = $urandom;
            it.report_present = 1'($urandom_range(1));
            it.free_reported  = 8'($urandom_range(255));
            it.buf_avail      = 12'($urandom_range(4095));
            it.frame_len      = 12'($urandom_range(4095));
            it.link_accept    = 1'($urandom_range(1));
        end
        return it;
    endfunction

    // Offers one item beat, after a random gap, and returns at the rising
    // edge that takes it. Valid is left high: the next call either drives a
    // new beat in the same time step or drops valid for a gap.
    task automatic send_item(input item_t it);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
        begin
            gap++;
        end
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        @(negedge clk);
        while (!req_ch.ready)
        begin
            @(negedge clk);
        end
        // The beat is taken at the coming edge; the ledger moves now.
        awaited_status.push_back(advance_credit(it));
        @(posedge clk);
    endtask

    // Stops sending and waits until every predicted status beat has come.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (awaited_status.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One configuration beat; valid stays high for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.wdata <= value;
        @(negedge clk);
        while (!cfg_ch.ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // Writes all three registers. Called only while the block is drained.
    task automatic set_regs(input logic [15:0] tmo, input logic [7:0] slots,
                            input logic [7:0] chunk);
        write_reg(CFG_TIMEOUT_MS, tmo);
        write_reg(CFG_SLOT_COUNT, {8'd0, slots});
        write_reg(CFG_CHUNK_MAX, {8'd0, chunk});
        cfg_ch.valid <= 1'b0;
        cfg_timeout = tmo;
        cfg_slots   = slots;
        cfg_chunk   = chunk;
    endtask

    // Reset values of the registers, walking through chunk attempts refused for an
    // empty buffer, an empty frame and a refusing link, oversized buffer figures,
    // credit return from a report and timeout checks on both sides of the limit.
    task automatic test_reset_defaults();
        send_item(make_item(REQ_REPORT, 32'd100, 1'b0, 8'd3, 12'd0, 12'd0, 1'b0));
        send_item(make_item(REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, 8'hFF, 12'hFFF, 12'hFFF, 1'b1));
        send_item(make_item(REQ_TIMEOUT, 32'd100000, 1'b0, 8'd0, 12'd0, 12'd0, 1'b0));
        send_item(make_item(REQ_CHUNK, 32'd200, 1'b0, 8'd0, 12'd0, 12'd100, 1'b1));
        send_item(make_item(REQ_CHUNK, 32'd201, 1'b0, 8'd0, 12'd50, 12'd0, 1'b1));
        // The link refuses, but the frame length is latched all the same.
        send_item(make_item(REQ_CHUNK, 32'd202, 1'b0, 8'd0, 12'd50, 12'd70, 1'b0));
        send_item(make_item(REQ_CHUNK, 32'd203, 1'b0, 8'd0, 12'd50, 12'd999, 1'b1));
        send_item(make_item(REQ_CHUNK, 32'd204, 1'b0, 8'd0, 12'hFFF, 12'hFFF, 1'b1));
        send_item(make_item(REQ_CHUNK, 32'd205, 1'b0, 8'd0, 12'hFFF, 12'hFFF, 1'b1));
        send_item(make_item(REQ_REPORT, 32'd2000, 1'b1, 8'hFF, 12'd0, 12'd0, 1'b0));
        send_item(make_item(REQ_CHUNK, 32'd2001, 1'b0, 8'd0, 12'd100, 12'd0, 1'b1));
        send_item(make_item(REQ_TIMEOUT, 32'd2500, 1'b0, 8'd0, 12'd0, 12'd0, 1'b0));
        send_item(make_item(REQ_TIMEOUT, 32'd2501, 1'b0, 8'd0, 12'd0, 12'd0, 1'b0));
        wait_drained();
    endtask

    // Smallest and largest legal register values, including a timeout check
    // whose elapsed time wraps through zero.
    task automatic test_register_extremes();
        set_regs(16'd0, 8'd1, 8'd1);
        send_item(make_item(REQ_REPORT, 32'hFFFF_FFF0, 1'b1, 8'd0, 12'd0, 12'd0, 1'b0));
        send_item(make_item(REQ_CHUNK, 32'hFFFF_FFF0, 1'b0, 8'd0, 12'd1, 12'd1, 1'b1));
        send_item(make_item(REQ_TIMEOUT, 32'hFFFF_FFF0, 1'b0, 8'd0, 12'd0, 12'd0, 1'b0));
        send_item(make_item(REQ_TIMEOUT, 32'h0000_0005, 1'b0, 8'd0, 12'd0, 12'd0, 1'b0));
        wait_drained();

        set_regs(16'hFFFF, 8'hFF, 8'hFF);
        send_item(make_item(REQ_CHUNK, 32'd10, 1'b0, 8'd0, 12'd2048, 12'd2048, 1'b1));
        send_item(make_item(REQ_REPORT, 32'd20, 1'b1, 8'hFF, 12'd0, 12'd0, 1'b0));
        send_item(make_item(REQ_CHUNK, 32'd30, 1'b0, 8'd0, 12'd2048, 12'd0, 1'b1));
        send_item(make_item(REQ_TIMEOUT, 32'd65555, 1'b0, 8'd0, 12'd0, 12'd0, 1'b0));
        send_item(make_item(REQ_TIMEOUT, 32'd65556, 1'b0, 8'd0, 12'd0, 12'd0, 1'b0));
        wait_drained();
    endtask

    // A slot count of zero leaves no slot free and clamps reports to zero;
    // a chunk maximum of zero makes every attempt stop.
    task automatic test_zero_registers();
        set_regs(16'd500, 8'd0, 8'd0);
        send_item(make_item(REQ_CHUNK, 32'd40, 1'b0, 8'd0, 12'd100, 12'd100, 1'b1));
        send_item(make_item(REQ_REPORT, 32'd41, 1'b1, 8'd9, 12'd0, 12'd0, 1'b0));
        wait_drained();
        set_regs(16'd500, 8'd4, 8'd0);
        send_item(make_item(REQ_CHUNK, 32'd42, 1'b0, 8'd0, 12'd100, 12'd100, 1'b1));
        wait_drained();
    endtask

    // Phases of random traffic, each under its own register setting. Halfway
    // through every phase the sender holds off until all status has come.
    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned i;
        for (phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
            begin
                set_regs(16'd0, 8'd1, 8'd1);
            end
            else if (phase == 5)
            begin
                set_regs(16'hFFFF, 8'hFF, 8'hFF);
            end
            else
            begin
                set_regs(16'($urandom_range(1000)), 8'($urandom_range(8, 1)),
                         8'($urandom_range(255, 1)));
            end
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2)
                begin
                    wait_drained();
                end
                send_item(random_item());
            end
            wait_drained();
        end
    endtask

    // A long stretch with beats back to back on both channels.
    task automatic test_back_to_back();
        int unsigned i;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        set_regs(16'($urandom_range(300)), 8'($urandom_range(6, 1)),
                 8'($urandom_range(64, 1)));
        for (i = 0; i < STREAM_ITEMS; i++)
        begin
            send_item(random_item());
        end
        wait_drained();
        src_idle_pct   = IDLE_PCT;
        sink_stall_pct = IDLE_PCT;
    endtask

    // Status consumer: takes a beat when valid and ready were both high at the
    // falling edge, and checks it once the rising edge has taken it.
    initial
    begin : status_check
        result_t seen;
        result_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                seen = rsp_ch.data;
                @(posedge clk);
                if (awaited_status.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: status beat with none expected", $realtime);
                        $display("    len %0d stop %0d free %0d owed %0d",
                                 seen.chunk_len, seen.stop, seen.slots_free,
                                 seen.outstanding_now);
                    end
                end
                else
                begin
                    want = awaited_status.pop_front();
                    if (seen.chunk_len !== want.chunk_len || seen.stop !== want.stop ||
                        seen.slots_free !== want.slots_free ||
                        seen.outstanding_now !== want.outstanding_now)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: status mismatch", $realtime);
                            $display("    expected len %0d stop %0d free %0d owed %0d",
                                     want.chunk_len, want.stop, want.slots_free,
                                     want.outstanding_now);
                            $display("    actual   len %0d stop %0d free %0d owed %0d",
                                     seen.chunk_len, seen.stop, seen.slots_free,
                                     seen.outstanding_now);
                        end
                    end
                end
            end
        end
    end

    // Status ready, dropped at random to stall the block's output.
    initial
    begin : status_sink
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Ends a hung run.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("radio_credit_chunk_sender regression: fail");
        $finish;
    end

    initial
    begin : run
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_TIMEOUT_MS;
        cfg_ch.wdata = '0;
        rst_n        = 1'b0;

        cfg_timeout     = TIMEOUT_MS_RESET;
        cfg_slots       = SLOT_COUNT_RESET;
        cfg_chunk       = CHUNK_MAX_RESET;
        owed_chunks     = 8'd0;
        prev_free       = 8'd0;
        prev_report_ms  = 32'd0;
        report_heard    = 1'b0;
        frame_remaining = 12'd0;
        fault_count     = 0;
        src_idle_pct    = IDLE_PCT;
        sink_stall_pct  = IDLE_PCT;
        sim_ms          = 32'd0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_zero_registers();
        test_random_traffic();
        test_back_to_back();
        wait_drained();

        if (fault_count == 0)
        begin
            $display("radio_credit_chunk_sender regression: pass");
        end
        else
        begin
            $display("radio_credit_chunk_sender regression: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/rccs_pkg.sv
hdl/rccs_if.sv
hdl/rccs_cfg_regs.sv
hdl/rccs_credit_core.sv
hdl/radio_credit_chunk_sender.sv
test/tb.sv
